FILE: rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared sizes, register codes and controller/datapath handshake types for
// the first-fit slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

   // Table geometry
   localparam int ROWS          = 4;
   localparam int SLOTS_PER_ROW = 16;
   localparam int OWNER_BITS    = 8;

   localparam int TABLE_DEPTH   = ROWS * SLOTS_PER_ROW;
   localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
   localparam int ROW_BITS      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_BITS     = $clog2(SLOTS_PER_ROW);
   localparam int ROW_CNT_BITS  = $clog2(ROWS + 1);
   localparam int SLOT_CNT_BITS = $clog2(SLOTS_PER_ROW + 1);

   // Configuration registers
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;
   localparam int ROWS_REG_BITS  = 3;
   localparam int SLOTS_REG_BITS = 5;
   localparam logic [ROWS_REG_BITS-1:0]  ROWS_REG_RESET  = 3'd4;
   localparam logic [SLOTS_REG_BITS-1:0] SLOTS_REG_RESET = 5'd16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROWS_IN_USE  = 1'b0,
      CSR_SLOTS_IN_USE = 1'b1
   } csr_index_type;

   // Result field widths
   localparam int ROW_FOUND_BITS  = 2;
   localparam int SLOT_FOUND_BITS = 4;

   // Stream widths
   localparam int REQ_TDATA_BITS = ((OWNER_BITS + 7) / 8) * 8;
   localparam int REQ_TUSER_BITS = 2;
   localparam int RSP_FIELD_BITS = 1 + ROW_FOUND_BITS + SLOT_FOUND_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Request kinds
   localparam logic MODE_ALLOCATE = 1'b0;
   localparam logic MODE_RELEASE  = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic write_first;
      logic write_second;
      logic publish;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hit;
      logic miss;
      logic pair;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

FILE: rtl/ffsa_ram.sv
// ----------------------------------------------------------------------------
// ffsa_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Request sequencer: load, scan, write back, and hand the result to the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_ctrl import ffsa_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE_A,
      ST_WRITE_B,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      req_tready_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               state_in = ST_WRITE_A;
            end else if (sts.miss) begin
               state_in = ST_RESULT;
            end
         end
         ST_WRITE_A: begin
            cmd.write_first = 1'b1;
            state_in = sts.pair ? ST_WRITE_B : ST_RESULT;
         end
         ST_WRITE_B: begin
            cmd.write_second = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         req_tready_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         req_tready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_tready = req_tready_ff;

endmodule

`default_nettype wire

FILE: rtl/ffsa_datapath.sv
// ----------------------------------------------------------------------------
// ffsa_datapath
// Configuration registers, owner table with per-entry valid bits, scan
// pipeline, hit detection, write-back and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_datapath import ffsa_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // configuration
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_wdata,
   // request fields
   input  wire logic                       req_mode,
   input  wire logic [OWNER_BITS-1:0]      req_owner,
   input  wire logic                       req_double,
   // sequencer
   input  wire dp_cmd_type                 cmd,
   output dp_sts_type                      sts,
   // result
   input  wire logic                       rsp_tready,
   output logic                            rsp_tvalid,
   output logic                            rsp_ok,
   output logic [ROW_FOUND_BITS-1:0]       rsp_row,
   output logic [SLOT_FOUND_BITS-1:0]      rsp_slot
);

   // Configuration registers
   logic [ROWS_REG_BITS-1:0]  rows_reg_ff;
   logic [SLOTS_REG_BITS-1:0] slots_reg_ff;

   // Request context
   logic                     mode_ff;
   logic                     dbl_ff;
   logic [OWNER_BITS-1:0]    tag_ff;
   logic [ROW_CNT_BITS-1:0]  nrows_ff,  nrows_in;
   logic [SLOT_CNT_BITS-1:0] nslots_ff, nslots_in;
   logic                     empty_ff,  empty_in;

   // Read issue counters
   logic                 issue_active_ff;
   logic [ROW_BITS-1:0]  issue_row_ff;
   logic [SLOT_BITS-1:0] issue_slot_ff;
   logic [ADDR_BITS-1:0] issue_addr;
   logic                 issue_row_last;
   logic                 issue_slot_last;

   // Check stage, registered alongside the read data
   logic                 chk_valid_ff;
   logic [ROW_BITS-1:0]  chk_row_ff;
   logic [SLOT_BITS-1:0] chk_slot_ff;
   logic                 chk_last_ff;
   logic                 rd_live_ff;
   logic                 prev_free_ff;
   logic [OWNER_BITS-1:0] ram_rdata;
   logic [OWNER_BITS-1:0] rd_tag;
   logic                 cur_free;
   logic                 cur_match;
   logic                 pair_room;
   logic                 hit_now;
   logic [SLOT_BITS-1:0] hit_slot;

   // Found position
   logic                 found_ff;
   logic [ROW_BITS-1:0]  found_row_ff;
   logic [SLOT_BITS-1:0] found_slot_ff;
   logic [ADDR_BITS-1:0] found_addr;

   // Table write side
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [OWNER_BITS-1:0] wr_data;
   logic                  entry_valid_ff [TABLE_DEPTH];

   // Result register
   logic                       rsp_valid_ff;
   logic                       rsp_ok_ff;
   logic [ROW_FOUND_BITS-1:0]  rsp_row_ff;
   logic [SLOT_FOUND_BITS-1:0] rsp_slot_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_reg_ff  <= ROWS_REG_RESET;
         slots_reg_ff <= SLOTS_REG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ROWS_IN_USE:  rows_reg_ff  <= csr_wdata[ROWS_REG_BITS-1:0];
            CSR_SLOTS_IN_USE: slots_reg_ff <= csr_wdata[SLOTS_REG_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp the search range to the table and flag requests with a zero owner or nothing to search
   always_comb begin
      nrows_in  = (32'(rows_reg_ff) > ROWS) ? ROW_CNT_BITS'(ROWS)
                                            : ROW_CNT_BITS'(rows_reg_ff);
      nslots_in = (32'(slots_reg_ff) > SLOTS_PER_ROW) ? SLOT_CNT_BITS'(SLOTS_PER_ROW)
                                                      : SLOT_CNT_BITS'(slots_reg_ff);
      empty_in  = (req_owner == '0) || (nrows_in == '0) || (nslots_in == '0);
   end

   // Read address and end of scan
   assign issue_addr      = ADDR_BITS'(issue_row_ff * SLOTS_PER_ROW) + ADDR_BITS'(issue_slot_ff);
   assign issue_row_last  = (ROW_CNT_BITS'(issue_row_ff) == nrows_ff - ROW_CNT_BITS'(1));
   assign issue_slot_last = (SLOT_CNT_BITS'(issue_slot_ff) == nslots_ff - SLOT_CNT_BITS'(1));

   // Compare the entry read in the previous cycle
   assign rd_tag    = rd_live_ff ? ram_rdata : '0;
   assign cur_free  = (rd_tag == '0);
   assign cur_match = (rd_tag == tag_ff);
   assign pair_room = (SLOT_CNT_BITS'(chk_slot_ff) + SLOT_CNT_BITS'(1)) < nslots_ff;

   always_comb begin
      hit_slot = chk_slot_ff;
      if (mode_ff == MODE_RELEASE) begin
         hit_now = cur_match && (!dbl_ff || pair_room);
      end else if (dbl_ff) begin
         // pair ends at this slot, so it starts one to the left
         hit_now  = cur_free && prev_free_ff && (chk_slot_ff != '0);
         hit_slot = chk_slot_ff - SLOT_BITS'(1);
      end else begin
         hit_now = cur_free;
      end
   end

   assign sts.hit      = chk_valid_ff && hit_now;
   assign sts.miss     = empty_ff || (chk_valid_ff && chk_last_ff && !hit_now);
   assign sts.pair     = dbl_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   // Load request, advance the scan, capture the hit
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_active_ff <= 1'b0;
         chk_valid_ff    <= 1'b0;
         empty_ff        <= 1'b0;
         found_ff        <= 1'b0;
      end else begin
         if (cmd.load) begin
            mode_ff         <= req_mode;
            dbl_ff          <= req_double;
            tag_ff          <= req_owner;
            nrows_ff        <= nrows_in;
            nslots_ff       <= nslots_in;
            empty_ff        <= empty_in;
            issue_active_ff <= !empty_in;
            issue_row_ff    <= '0;
            issue_slot_ff   <= '0;
            found_ff        <= 1'b0;
            found_row_ff    <= '0;
            found_slot_ff   <= '0;
         end else if (cmd.scan && issue_active_ff) begin
            if (issue_slot_last) begin
               issue_slot_ff <= '0;
               issue_row_ff  <= issue_row_ff + ROW_BITS'(1);
               if (issue_row_last) begin
                  issue_active_ff <= 1'b0;
               end
            end else begin
               issue_slot_ff <= issue_slot_ff + SLOT_BITS'(1);
            end
         end
         chk_valid_ff <= cmd.scan && issue_active_ff && !cmd.load;
         if (cmd.scan && sts.hit) begin
            found_ff      <= 1'b1;
            found_row_ff  <= chk_row_ff;
            found_slot_ff <= hit_slot;
         end
      end
   end

   // Check-stage tags travel with the read
   always_ff @(posedge clock) begin
      chk_row_ff  <= issue_row_ff;
      chk_slot_ff <= issue_slot_ff;
      chk_last_ff <= issue_row_last && issue_slot_last;
      rd_live_ff  <= entry_valid_ff[issue_addr];
      if (chk_valid_ff) begin
         prev_free_ff <= cur_free;
      end
   end

   // Write back the owner tag, or zero on release
   assign found_addr = ADDR_BITS'(found_row_ff * SLOTS_PER_ROW) + ADDR_BITS'(found_slot_ff);
   assign wr_en      = cmd.write_first || cmd.write_second;
   assign wr_addr    = found_addr + (cmd.write_second ? ADDR_BITS'(1) : ADDR_BITS'(0));
   assign wr_data    = (mode_ff == MODE_RELEASE) ? '0 : tag_ff;

   // Entries never written read as free
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         entry_valid_ff[wr_addr] <= 1'b1;
      end
   end

   ffsa_ram #(
      .WIDTH (OWNER_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (issue_addr),
      .rd_data (ram_rdata)
   );

   // Result register: load on publish, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_ok_ff   <= found_ff;
         rsp_row_ff  <= ROW_FOUND_BITS'(found_row_ff);
         rsp_slot_ff <= SLOT_FOUND_BITS'(found_slot_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_ok     = rsp_ok_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

`default_nettype wire

FILE: rtl/first_fit_slot_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_slot_allocator
// First-fit allocator over a table of owner tags arranged as rows of slots.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request is scanned one table entry per
// clock through the table's single read port, rows in order and slots in
// order, stopping at the first hit; on a hit the slot, or both slots of a
// pair, is written back, and the result is then handed to the output
// register before the return to idle. The worst case from one accepted
// request beat to the next is set by a scan over every entry in use. A
// finished result waits in an output register, so the next request is
// accepted while it is still pending. The table reads as all free after
// reset with no clearing pass. Write configuration only while no request is
// outstanding.
`default_nettype none

module first_fit_slot_allocator import ffsa_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // configuration write port
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   // request stream
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_TDATA_BITS-1:0] req_tdata,   // owner
   input  wire logic [REQ_TUSER_BITS-1:0] req_tuser,   // mode, double_width
   // response stream
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0]      rsp_tdata    // ok, row_found, slot_found
);

   dp_cmd_type                 dp_cmd;
   dp_sts_type                 dp_sts;
   logic                       rsp_ok;
   logic [ROW_FOUND_BITS-1:0]  rsp_row;
   logic [SLOT_FOUND_BITS-1:0] rsp_slot;

   ffsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (dp_sts),
      .cmd        (dp_cmd)
   );

   ffsa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_mode   (req_tuser[0]),
      .req_owner  (req_tdata[OWNER_BITS-1:0]),
      .req_double (req_tuser[1]),
      .cmd        (dp_cmd),
      .sts        (dp_sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_ok     (rsp_ok),
      .rsp_row    (rsp_row),
      .rsp_slot   (rsp_slot)
   );

   // Pack the response beat
   assign rsp_tdata = RSP_TDATA_BITS'({rsp_slot, rsp_row, rsp_ok});

   // One request in flight: ready drops after an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // A failed request reports position zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_ok) |-> (rsp_row == '0 && rsp_slot == '0))
      else $error("failed request carries a nonzero position");

   // The scan never reports a hit and a miss together
   assert property (@(posedge clock) disable iff (reset)
      !(dp_sts.hit && dp_sts.miss))
      else $error("scan reports hit and miss at once");

   // Write-back happens only for a request that found a slot
   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.write_first |-> $past(dp_cmd.scan && dp_sts.hit))
      else $error("write-back without a scan hit");

endmodule

`default_nettype wire

FILE: tb/first_fit_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// first_fit_slot_allocator_tb
// Self-checking bench for the first-fit slot allocator.
// ----------------------------------------------------------------------------
// A mirror of the owner table and of both search-limit registers predicts
// the grant for every accepted request beat. A monitor compares each response
// beat with the oldest pending grant. Stimulus runs hand-written requests
// first, then random traffic across a series of row/slot limits, with random
// stalls on both streams.
// ----------------------------------------------------------------------------

module first_fit_slot_allocator_tb import ffsa_pkg::*;;

   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 80;

   // Response fields, lowest bit first: ok, row_found, slot_found
   typedef struct packed {
      logic [SLOT_FOUND_BITS-1:0] slot;
      logic [ROW_FOUND_BITS-1:0]  row;
      logic                       ok;
   } grant_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_ROWS_IN_USE;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;   // owner
   logic [REQ_TUSER_BITS-1:0] req_tuser = '0;   // mode, double_width
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;        // ok, row_found, slot_found

   // Mirror of the allocator state
   logic [OWNER_BITS-1:0]     slot_owner [TABLE_DEPTH];
   logic [ROWS_REG_BITS-1:0]  rows_limit = ROWS_REG_RESET;
   logic [SLOTS_REG_BITS-1:0] slots_limit = SLOTS_REG_RESET;

   grant_type expected_grants [$];
   logic   no_idle = 1'b0;
   int     mismatches = 0;
   int     requests_sent = 0;
   int     releases_sent = 0;
   int     grants_ok = 0;
   int     grants_refused = 0;
   int     settings_used = 1;
   int     idle_cycles = 0;

   first_fit_slot_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Scan the mirror for the first fit and apply the allocate or release
   function automatic grant_type predict_grant(logic mode, logic [OWNER_BITS-1:0] owner,
                                               logic dbl);
      grant_type grant;
      int     nrows, nslots, last_start, base, hit_row, hit_slot;
      logic   hit;
      grant = '0;
      hit_row = 0;
      hit_slot = 0;
      nrows = (rows_limit > ROWS) ? ROWS : rows_limit;
      nslots = (slots_limit > SLOTS_PER_ROW) ? SLOTS_PER_ROW : slots_limit;
      // a pair must start one slot short of the searched range
      last_start = dbl ? ((nslots > 0) ? nslots - 1 : 0) : nslots;
      if (owner != '0) begin
         for (int r = 0; r < nrows && !grant.ok; r++) begin
            for (int s = 0; s < last_start && !grant.ok; s++) begin
               base = r * SLOTS_PER_ROW + s;
               if (mode == MODE_RELEASE)
                  hit = (slot_owner[base] == owner);
               else if (dbl)
                  hit = (slot_owner[base] == '0) && (slot_owner[base + 1] == '0);
               else
                  hit = (slot_owner[base] == '0);
               if (hit) begin
                  grant.ok = 1'b1;
                  hit_row = r;
                  hit_slot = s;
               end
            end
         end
      end
      if (grant.ok) begin
         grant.row = hit_row[ROW_FOUND_BITS-1:0];
         grant.slot = hit_slot[SLOT_FOUND_BITS-1:0];
         base = hit_row * SLOTS_PER_ROW + hit_slot;
         // a double release frees the neighbor whatever it holds
         slot_owner[base] = (mode == MODE_RELEASE) ? '0 : owner;
         if (dbl)
            slot_owner[base + 1] = (mode == MODE_RELEASE) ? '0 : owner;
      end
      return grant;
   endfunction

   // Drive one request beat and record its grant once accepted
   task automatic send_request(logic mode, logic [OWNER_BITS-1:0] owner, logic dbl);
      int gap;
      gap = (!no_idle && $urandom_range(99) < 18) ? $urandom_range(1, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_TDATA_BITS'(owner);
      req_tuser <= {dbl, mode};
      do @(posedge clock); while (!req_tready);
      expected_grants.push_back(predict_grant(mode, owner, dbl));
      requests_sent++;
      if (mode == MODE_RELEASE)
         releases_sent++;
   endtask

   // Hold off requests until every pending grant has been returned
   task automatic wait_for_grants();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_grants.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      wait_for_grants();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_ROWS_IN_USE)
         rows_limit = value[ROWS_REG_BITS-1:0];
      else
         slots_limit = value[SLOTS_REG_BITS-1:0];
   endtask

   task automatic set_limits(int rows_value, int slots_value);
      write_register(CSR_ROWS_IN_USE, CSR_DATA_BITS'(rows_value));
      write_register(CSR_SLOTS_IN_USE, CSR_DATA_BITS'(slots_value));
      settings_used++;
   endtask

   // Empty table, refused owner, missing owner, double release over a neighbor
   task automatic test_basic_requests();
      send_request(MODE_ALLOCATE, 8'd1, 1'b0);
      send_request(MODE_ALLOCATE, 8'd255, 1'b1);
      send_request(MODE_ALLOCATE, 8'd0, 1'b0);
      send_request(MODE_RELEASE, 8'd0, 1'b1);
      send_request(MODE_RELEASE, 8'd77, 1'b0);
      send_request(MODE_ALLOCATE, 8'd4, 1'b0);
      send_request(MODE_ALLOCATE, 8'd5, 1'b0);
      send_request(MODE_RELEASE, 8'd4, 1'b1);
      send_request(MODE_RELEASE, 8'd5, 1'b0);
      send_request(MODE_RELEASE, 8'd255, 1'b1);
      send_request(MODE_ALLOCATE, 8'd2, 1'b1);
      send_request(MODE_RELEASE, 8'd1, 1'b0);
      send_request(MODE_ALLOCATE, 8'h80, 1'b0);
      send_request(MODE_ALLOCATE, 8'h7f, 1'b1);
   endtask

   // Zero limits, saturating limits and the one- and two-slot pair ranges
   task automatic test_register_extremes();
      set_limits(0, 16);
      send_request(MODE_ALLOCATE, 8'd3, 1'b0);
      send_request(MODE_RELEASE, 8'd2, 1'b0);
      set_limits(7, 31);
      send_request(MODE_ALLOCATE, 8'd9, 1'b1);
      send_request(MODE_RELEASE, 8'd9, 1'b1);
      set_limits(4, 0);
      send_request(MODE_ALLOCATE, 8'd9, 1'b0);
      set_limits(4, 1);
      send_request(MODE_ALLOCATE, 8'd9, 1'b1);
      send_request(MODE_ALLOCATE, 8'd9, 1'b0);
      send_request(MODE_RELEASE, 8'd9, 1'b1);
      set_limits(4, 2);
      send_request(MODE_ALLOCATE, 8'd10, 1'b1);
      send_request(MODE_RELEASE, 8'd9, 1'b0);
   endtask

   // Random fill and drain bursts under one pair of limits
   task automatic test_random_traffic(int rows_value, int slots_value, int count,
                                      logic quiet);
      int   release_pct, pick;
      logic [OWNER_BITS-1:0] owner;
      set_limits(rows_value, slots_value);
      no_idle = quiet;
      release_pct = 30;
      for (int i = 0; i < count; i++) begin
         // alternate between filling and draining the table
         if (i % 40 == 0)
            release_pct = ((i / 40) % 2 == 0) ? $urandom_range(10, 35)
                                              : $urandom_range(60, 90);
         // let the sender sit until every grant is back
         if (i == count / 2)
            wait_for_grants();
         pick = $urandom_range(99);
         if (pick < 6)
            owner = '0;
         else if (pick < 36)
            owner = OWNER_BITS'($urandom_range(1, 255));
         else
            owner = OWNER_BITS'($urandom_range(1, 6));
         send_request(($urandom_range(99) < release_pct) ? MODE_RELEASE : MODE_ALLOCATE,
                      owner, $urandom_range(99) < 40);
      end
      no_idle = 1'b0;
   endtask

   // Response side stalls
   always @(negedge clock)
      rsp_tready <= no_idle || ($urandom_range(99) >= 18);

   // Compare each response beat with the oldest grant
   always @(posedge clock) begin
      grant_type seen, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = grant_type'(rsp_tdata[RSP_FIELD_BITS-1:0]);
         if (expected_grants.size() == 0) begin
            $error("response beat with no request pending: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_grants.pop_front();
            if (seen.ok !== want.ok) begin
               $error("ok: expected %0d actual %0d", want.ok, seen.ok);
               mismatches++;
            end
            if (seen.row !== want.row) begin
               $error("row_found: expected %0d actual %0d", want.row, seen.row);
               mismatches++;
            end
            if (seen.slot !== want.slot) begin
               $error("slot_found: expected %0d actual %0d", want.slot, seen.slot);
               mismatches++;
            end
            if (want.ok)
               grants_ok++;
            else
               grants_refused++;
         end
      end
   end

   // Watchdog: end the run when neither stream moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      foreach (slot_owner[i])
         slot_owner[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_requests();
      test_register_extremes();
      test_random_traffic(4, 16, 150, 1'b1);
      test_random_traffic(1, 1, 80, 1'b0);
      test_random_traffic(1, 2, 80, 1'b0);
      test_random_traffic(7, 31, 150, 1'b0);
      test_random_traffic(0, 16, 30, 1'b0);
      test_random_traffic(4, 0, 30, 1'b0);
      test_random_traffic(2, 9, 100, 1'b0);
      test_random_traffic(3, 16, 130, 1'b0);
      repeat (6)
         test_random_traffic($urandom_range(1, 4), $urandom_range(1, 16), 110, 1'b0);

      // drain and let any stray beat show up
      wait_for_grants();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d releases) over %0d row/slot limit settings.",
               requests_sent, releases_sent, settings_used);
      $display("Grants returned: %0d found, %0d refused or not found; %0d mismatches.",
               grants_ok, grants_refused, mismatches);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
